@@ sv/box_blur_3x3_edge_clamp_defines.svh @@
// Assertion macros for the 3x3 box blur block.
// Define ASSERT_OFF to compile the checks out.
`ifndef BOX_BLUR_3X3_EDGE_CLAMP_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLAMP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define BBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("box blur assertion failed");
// Condition must never be true outside reset.
`define BBC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("box blur forbidden condition seen");
`else
`define BBC_ASSERT(lbl, prop)
`define BBC_NEVER(lbl, cond)
`endif

`endif

@@ sv/bbc_pkg.sv @@
`default_nettype none

package bbc_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int FW_W      = 11;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int SUM_W     = 12;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

	// Result kinds, one bit each in the pending mask
	localparam int KIND_INNER      = 0;  // (x-1, y-1)
	localparam int KIND_ROW_END    = 1;  // (x,   y-1)
	localparam int KIND_LAST_INNER = 2;  // (x-1, y)
	localparam int KIND_LAST_END   = 3;  // (x,   y)
	localparam int NKIND           = 4;

	// floor(s/9) for s below 2296: 7282/65536 is close enough to 1/9
	localparam logic [12:0] RECIP9 = 13'd7282;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [NKIND-1:0] kind_mask_t;

	function automatic logic [CH_W-1:0] div9(input sum_t s);
		logic [SUM_W+12:0] p;
		p = s * RECIP9;
		return p[23:16];
	endfunction

endpackage

`default_nettype wire

@@ sv/box_blur_3x3_edge_clamp.sv @@
// 3x3 box blur with edge clamping over a raster-order pixel stream. Each pixel
// beat carries three 8-bit samples (the second and third are dropped in
// one-channel mode) and each result beat carries the per-channel floor of the
// neighbourhood sum over nine, plus its own column and row, since last-row
// results leave raster order. Pixel (x,y) releases (x-1,y-1); a row-end pixel
// also releases (W-1,y-1), and pixels of the last row also release their
// last-row results, up to four per pixel. The output stage sends one result a
// cycle while out_ready holds, so a pixel with several results holds the input
// until its last one is sent: one pixel a clock inside the frame while the
// output does not stall. That single result port sets the rate; the line
// stores take one read and one write per pixel. A pixel passes stages 1, 2 and
// 3 and the output register before its first result beat. The two line stores
// are never cleared, and the block is ready right after reset. Write
// frame_width, frame_height and color_mode only while the block is idle.
`default_nettype none

`include "box_blur_3x3_edge_clamp_defines.svh"

module box_blur_3x3_edge_clamp
	import bbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CH_W-1:0]      sample_a,
	input  wire logic [CH_W-1:0]      sample_b,
	input  wire logic [CH_W-1:0]      sample_c,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CH_W-1:0]           smooth_a,
	output logic [CH_W-1:0]           smooth_b,
	output logic [CH_W-1:0]           smooth_c,
	output logic [COL_W-1:0]          out_col,
	output logic [ROW_W-1:0]          out_row,
	output logic                      last_of_run,
	output logic                      frame_done
);

	// Configuration and position counters
	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic             color_mode_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Line stores and their read data
	pixel_t prev_mem  [MAX_WIDTH];
	pixel_t older_mem [MAX_WIDTH];
	pixel_t prev_rd_q;
	pixel_t older_rd_q;

	// Stage 1: pixel waiting for line store data
	logic             valid_s1;
	pixel_t           cur_s1;
	logic [COL_W-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;
	logic             row_end_s1;
	logic             last_row_s1;
	logic             fwd_hit_s1;
	pixel_t           fwd_prev_s1;
	pixel_t           fwd_older_s1;

	// Stage 2: window holds the neighbourhood, results go out one by one
	pixel_t           win_q [3][3];
	logic             valid_s2;
	logic [COL_W-1:0] x_s2;
	logic [ROW_W-1:0] y_s2;
	logic             frame_end_s2;
	kind_mask_t       pending_s2;

	// Stage 3: channel sums
	logic             valid_s3;
	sum_t             sum_a_s3;
	sum_t             sum_b_s3;
	sum_t             sum_c_s3;
	logic [COL_W-1:0] col_s3;
	logic [ROW_W-1:0] row_s3;
	logic             last_s3;
	logic             done_s3;

	// Output register
	logic             valid_q;
	logic [CH_W-1:0]  smooth_a_q;
	logic [CH_W-1:0]  smooth_b_q;
	logic [CH_W-1:0]  smooth_c_q;
	logic [COL_W-1:0] col_q_out;
	logic [ROW_W-1:0] row_q_out;
	logic             last_q;
	logic             done_q;

	// Flow control
	logic o_free, s3_free, s2_emit, s2_last, s2_free, s1_move, in_acc;

	// Frame geometry
	logic [FW_W-1:0]  w_eff;
	logic [FW_W-1:0]  w_last;
	logic [ROW_W-1:0] h_last;
	logic             row_end;
	logic             last_row;
	pixel_t           cur_pix;

	// Stage 1 line store data after forwarding
	pixel_t above_s1;
	pixel_t older_s1;
	kind_mask_t pending_new;

	// Result selection
	kind_mask_t       kind_oh;
	kind_mask_t       pending_rest;
	logic             horiz_end;
	logic             vert_last;
	logic [1:0]       csel [3];
	logic [1:0]       rsel [3];
	logic [SUM_W-1:0] colsum [3][3];  // [column][channel]
	sum_t             total [3];
	logic [COL_W-1:0] res_col;
	logic [ROW_W-1:0] res_row;

	// Handshake chain, back to front
	assign o_free   = !valid_q || out_ready;
	assign s3_free  = !valid_s3 || o_free;
	assign s2_emit  = valid_s2 && s3_free;
	assign s2_free  = !valid_s2 || (s3_free && s2_last);
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign in_acc   = in_valid && in_ready;

	// Clamp geometry and find row end and last row
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		w_last   = w_eff - FW_W'(1);
		h_last   = (frame_height_q == '0) ? '0 : frame_height_q - ROW_W'(1);
		row_end  = col_q >= w_last[COL_W-1:0];
		last_row = row_q >= h_last;
		cur_pix  = color_mode_q ? {sample_c, sample_b, sample_a}
		                        : {{(2*CH_W){1'b0}}, sample_a};
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(1);
			frame_height_q <= ROW_W'(1);
			color_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[ROW_W-1:0];
				REG_COLOR_MODE:   color_mode_q   <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Advance position on each pixel beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line stores: read at accept, write back when the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_rd_q  <= prev_mem[col_q];
			older_rd_q <= older_mem[col_q];
		end
		if (s1_move) begin
			prev_mem[x_s1]  <= cur_s1;
			older_mem[x_s1] <= above_s1;
		end
	end

	// Forward a write that lands on the entry read in the same cycle
	assign above_s1 = fwd_hit_s1 ? fwd_prev_s1  : prev_rd_q;
	assign older_s1 = fwd_hit_s1 ? fwd_older_s1 : older_rd_q;

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1       <= cur_pix;
			x_s1         <= col_q;
			y_s1         <= row_q;
			row_end_s1   <= row_end;
			last_row_s1  <= last_row;
			fwd_hit_s1   <= s1_move && (x_s1 == col_q);
			fwd_prev_s1  <= cur_s1;
			fwd_older_s1 <= above_s1;
		end
	end

	// Results this pixel releases
	always_comb begin
		pending_new                  = '0;
		pending_new[KIND_INNER]      = (y_s1 != '0) && (x_s1 != '0);
		pending_new[KIND_ROW_END]    = (y_s1 != '0) && row_end_s1;
		pending_new[KIND_LAST_INNER] = last_row_s1 && (x_s1 != '0);
		pending_new[KIND_LAST_END]   = last_row_s1 && row_end_s1;
	end

	// Shift the window on each pixel leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (s1_move) begin
			for (int c = 0; c < 2; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= win_q[c+1][r];
				end
			end
			win_q[2][0] <= older_s1;
			win_q[2][1] <= above_s1;
			win_q[2][2] <= cur_s1;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			pending_s2 <= '0;
		end else if (s1_move) begin
			valid_s2   <= pending_new != '0;
			pending_s2 <= pending_new;
		end else if (s2_emit) begin
			valid_s2   <= !s2_last;
			pending_s2 <= pending_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			x_s2         <= x_s1;
			y_s2         <= y_s1;
			frame_end_s2 <= row_end_s1 && last_row_s1;
		end
	end

	// Pick the lowest pending result and its clamped rows and columns
	always_comb begin
		kind_oh      = pending_s2 & (~pending_s2 + kind_mask_t'(1));
		pending_rest = pending_s2 & ~kind_oh;
		s2_last      = pending_rest == '0;
		horiz_end    = kind_oh[KIND_ROW_END] || kind_oh[KIND_LAST_END];
		vert_last    = kind_oh[KIND_LAST_INNER] || kind_oh[KIND_LAST_END];

		if (horiz_end) begin
			csel[0] = (x_s2 == '0) ? 2'd2 : 2'd1;
			csel[1] = 2'd2;
			csel[2] = 2'd2;
			res_col = x_s2;
		end else begin
			csel[0] = (x_s2 == COL_W'(1)) ? 2'd1 : 2'd0;
			csel[1] = 2'd1;
			csel[2] = 2'd2;
			res_col = x_s2 - COL_W'(1);
		end

		if (vert_last) begin
			rsel[0] = (y_s2 == '0) ? 2'd2 : 2'd1;
			rsel[1] = 2'd2;
			rsel[2] = 2'd2;
			res_row = y_s2;
		end else begin
			rsel[0] = (y_s2 == ROW_W'(1)) ? 2'd1 : 2'd0;
			rsel[1] = 2'd1;
			rsel[2] = 2'd2;
			res_row = y_s2 - ROW_W'(1);
		end
	end

	// Sum the chosen rows per column, then the chosen columns
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int ch = 0; ch < 3; ch++) begin
				colsum[c][ch] = SUM_W'(win_q[c][rsel[0]][ch*CH_W +: CH_W])
				              + SUM_W'(win_q[c][rsel[1]][ch*CH_W +: CH_W])
				              + SUM_W'(win_q[c][rsel[2]][ch*CH_W +: CH_W]);
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = colsum[csel[0]][ch] + colsum[csel[1]][ch] + colsum[csel[2]][ch];
		end
	end

	// Stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s2_emit) begin
			valid_s3 <= 1'b1;
		end else if (o_free) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_emit) begin
			sum_a_s3 <= total[0];
			sum_b_s3 <= total[1];
			sum_c_s3 <= total[2];
			col_s3   <= res_col;
			row_s3   <= res_row;
			last_s3  <= s2_last;
			done_s3  <= s2_last && frame_end_s2;
		end
	end

	// Divide by nine into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (o_free) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && o_free) begin
			smooth_a_q <= div9(sum_a_s3);
			smooth_b_q <= div9(sum_b_s3);
			smooth_c_q <= div9(sum_c_s3);
			col_q_out  <= col_s3;
			row_q_out  <= row_s3;
			last_q     <= last_s3;
			done_q     <= done_s3;
		end
	end

	assign out_valid   = valid_q;
	assign smooth_a    = smooth_a_q;
	assign smooth_b    = smooth_b_q;
	assign smooth_c    = smooth_c_q;
	assign out_col     = col_q_out;
	assign out_row     = row_q_out;
	assign last_of_run = last_q;
	assign frame_done  = done_q;

	// Checks
	`BBC_ASSERT(a_s2_has_work, valid_s2 |-> (pending_s2 != '0))
	`BBC_NEVER(a_done_without_last, out_valid && frame_done && !last_of_run)
	`BBC_ASSERT(a_s2_drains, (s2_emit && s2_last) |=> (!valid_s2 || $past(s1_move)))

endmodule

`default_nettype wire
